@@ hdl/ssort_pkg.sv @@
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared types and constants for the tagged Shell sort block.
// ----------------------------------------------------------------------------
package ssort_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned TAG_W = 7;
    localparam int unsigned ENT_W = KEY_W + TAG_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // IEEE single less-than: signed zeros equal, NaN never less
    function automatic logic f_key_less(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || both_zero) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = a[31];
        end else if (a[31]) begin
            res = a[30:0] > b[30:0];
        end else begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/ssort_if.sv @@
// ----------------------------------------------------------------------------
// ssort_in_if / ssort_out_if
// Valid/ready channels carrying input keys and sorted result items.
// ----------------------------------------------------------------------------
interface ssort_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_bits;
    logic        last_key;
    modport source (output valid, key_bits, last_key, input ready);
    modport sink   (input valid, key_bits, last_key, output ready);
endinterface

interface ssort_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sorted_key;
    logic [6:0]  origin_position;
    logic        last_result;
    logic        keys_dropped;
    modport source (output valid, sorted_key, origin_position, last_result,
                    keys_dropped, input ready);
    modport sink   (input valid, sorted_key, origin_position, last_result,
                    keys_dropped, output ready);
endinterface

@@ hdl/ssort_ram.sv @@
// ----------------------------------------------------------------------------
// ssort_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ssort_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/shell_sort_with_tags.sv @@
// ----------------------------------------------------------------------------
// shell_sort_with_tags
// Collects IEEE single keys with arrival tags and emits them sorted.
// ----------------------------------------------------------------------------
// Usage:
//   Keys arrive on i_in, one item per cycle while loading. Each key is
//   tagged with its 1-based arrival position. Keys beyond MAX_KEYS are
//   dropped and every result of that set is flagged. An item with
//   last_key set ends the set: the block then runs an ascending Shell sort
//   in the key/tag memory and streams all keys on o_out, last_result on
//   the final one. i_in.ready is low from the last key until the final
//   result is taken.
//   Sorting: each insertion runs S_OUTER, S_HOLD, S_CMP, one S_SHIFT per
//   compare and S_PLACE; each pass adds S_GAP for the gap update and the
//   closing S_OUTER bound check; bounded by the single memory read port.
//   Emission: each result runs S_ERD and S_EOUT plus any receiver stall;
//   results hold in the output register while o_out.ready is low.
//   Reset clears control state only; the memory needs no clearing.
// ----------------------------------------------------------------------------
module shell_sort_with_tags #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssort_in_if.sink    i_in,
    ssort_out_if.source o_out
);
    localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_GAP, S_OUTER, S_HOLD, S_CMP, S_SHIFT, S_PLACE,
        S_ERD, S_EOUT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [CW-1:0]    r_gap;
    logic [CW-1:0]    r_outer;
    logic [CW:0]      r_inner;
    ssort_pkg::t_entry r_held;
    logic [CW-1:0]    r_emit;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    ssort_pkg::t_entry w_wdata;
    ssort_pkg::t_entry w_rdata;

    logic [CW:0] w_gap_next;
    logic        w_in_acc;
    logic [CW:0] w_dst;

    ssort_ram #(.WIDTH(ssort_pkg::ENT_W), .DEPTH(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_gap_next = {1'b0, ((r_gap >> 2) << 1) | CW'(1)};
    // destination of a shift: inner + gap - 1 (inner is 1-based)
    assign w_dst      = r_inner + {1'b0, r_gap} - 1'b1;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_held;
        w_raddr = '0;
        case (r_state)
            S_LOAD: begin
                w_we         = w_in_acc && (r_count < CW'(MAX_KEYS));
                w_waddr      = r_count[AW-1:0];
                w_wdata.key  = i_in.key_bits;
                w_wdata.tag  = 7'(r_count + 1'b1);
            end
            S_OUTER: begin
                w_raddr = AW'(r_outer + r_gap - 1'b1);
            end
            S_CMP: begin
                w_raddr = AW'(r_inner - 1'b1);
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = w_dst[AW-1:0];
                w_wdata = w_rdata;
                w_raddr = AW'(r_inner - {1'b0, r_gap} - 1'b1);
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_waddr = w_dst[AW-1:0];
                w_wdata = r_held;
            end
            S_ERD: begin
                w_raddr = r_emit[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_gap       <= '0;
            r_outer     <= '0;
            r_inner     <= '0;
            r_emit      <= '0;
            o_out.valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count < CW'(MAX_KEYS)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last_key) begin
                            r_gap   <= (r_count < CW'(MAX_KEYS)) ? r_count + 1'b1
                                                               : r_count;
                            r_state <= S_GAP;
                        end
                    end
                end
                S_GAP: begin
                    r_emit <= '0;
                    if (r_count <= 1) begin
                        r_state <= S_ERD;
                    end else begin
                        r_gap   <= w_gap_next[CW-1:0];
                        r_outer <= CW'(1);
                        r_state <= S_OUTER;
                    end
                end
                S_OUTER: begin
                    if ({1'b0, r_outer} + {1'b0, r_gap} <= {1'b0, r_count}) begin
                        r_inner <= {1'b0, r_outer};
                        r_state <= S_HOLD;
                    end else if (r_gap == CW'(1)) begin
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_GAP;
                    end
                end
                S_HOLD: begin
                    r_held  <= w_rdata;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    // w_rdata holds entry inner-1 here
                    if (ssort_pkg::f_key_less(r_held.key, w_rdata.key)) begin
                        r_inner <= r_inner - {1'b0, r_gap};
                        if (r_inner <= {1'b0, r_gap}) begin
                            r_state <= S_PLACE;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_outer <= r_outer + 1'b1;
                    r_state <= S_OUTER;
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (!o_out.valid) begin
                        o_out.valid           <= 1'b1;
                        o_out.sorted_key      <= w_rdata.key;
                        o_out.origin_position <= w_rdata.tag;
                        o_out.last_result     <= (r_emit + 1'b1 == r_count);
                        o_out.keys_dropped    <= r_ovf;
                    end else if (o_out.ready) begin
                        o_out.valid <= 1'b0;
                        if (o_out.last_result) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_emit  <= r_emit + 1'b1;
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // S_SHIFT write and the next S_SHIFT read: the read addr (inner-gap-1)
    // differs from write addr (inner+gap-1), and the data read in the
    // previous cycle is what moves, so no forwarding is needed.

    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid) else $error("input open while emitting");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS)) else $error("count beyond capacity");
    a_gap_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUTER) |-> r_gap[0]) else $error("gap not odd");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_emit < r_count)) else $error("emit index overrun");
endmodule

@@ bench/tb_shell_sort_with_tags.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_sort_with_tags
// Sends key sets of many sizes (special values, ties, overflow) and checks
// every sorted key, tag and flag against an in-bench Shell sort predictor.
// ----------------------------------------------------------------------------
module tb_shell_sort_with_tags;

    localparam int unsigned MAX_KEYS = 64;
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        logic [ssort_pkg::KEY_W-1:0] key;
        logic [ssort_pkg::TAG_W-1:0] tag;
        logic                        last;
        logic                        dropped;
    } t_sorted;

    logic i_clk;
    logic i_rst_n;

    ssort_in_if  key_ch ();
    ssort_out_if res_ch ();

    shell_sort_with_tags #(.MAX_KEYS(MAX_KEYS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_ch.sink),
        .o_out   (res_ch.source)
    );

    logic [ssort_pkg::KEY_W-1:0] set_keys[$];
    logic [ssort_pkg::TAG_W-1:0] set_tags[$];
    logic             set_overflow;
    t_sorted          sorted_queue[$];
    int unsigned      mismatch_count = 0;
    int unsigned      idle_cycles;
    int unsigned      recv_idle;
    int unsigned      hold_count;
    bit               send_gaps;
    bit               recv_gaps;
    bit               hold_req;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic bit ieee_less(input logic [31:0] a, input logic [31:0] b);
        bit a_nan;
        bit b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
        if (a_nan || b_nan || (a[30:0] == 0 && b[30:0] == 0)) return 1'b0;
        if (a[31] != b[31]) return a[31];
        if (a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    task automatic predict_sorted_set();
        int n;
        int step;
        int pos;
        int slot;
        logic [31:0] hk;
        logic [6:0]  ht;
        t_sorted     r;
        n = set_keys.size();
        if (n > 1) begin
            step = n;
            do begin
                step = 2 * (step / 4) + 1;
                for (pos = 1; pos + step <= n; pos++) begin
                    hk = set_keys[pos + step - 1];
                    ht = set_tags[pos + step - 1];
                    slot = pos;
                    while (ieee_less(hk, set_keys[slot - 1])) begin
                        set_keys[slot + step - 1] = set_keys[slot - 1];
                        set_tags[slot + step - 1] = set_tags[slot - 1];
                        slot -= step;
                        if (slot <= 0) break;
                    end
                    set_keys[slot + step - 1] = hk;
                    set_tags[slot + step - 1] = ht;
                end
            end while (step != 1);
        end
        for (int k = 0; k < n; k++) begin
            r.key = set_keys[k];
            r.tag = set_tags[k];
            r.last = (k == n - 1);
            r.dropped = set_overflow;
            sorted_queue.push_back(r);
        end
        set_keys.delete();
        set_tags.delete();
        set_overflow = 1'b0;
    endtask

    task automatic send_key(input logic [31:0] key, input bit last);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            key_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        key_ch.valid    <= 1'b1;
        key_ch.key_bits <= key;
        key_ch.last_key <= last;
        do @(posedge i_clk); while (!key_ch.ready);
        if (set_keys.size() < MAX_KEYS) begin
            set_keys.push_back(key);
            set_tags.push_back(7'(set_keys.size()));
        end else begin
            set_overflow = 1'b1;
        end
        if (last) predict_sorted_set();
    endtask

    task automatic release_input();
        key_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 8388607))};
            3: return {1'($urandom_range(0, 1)), 8'hFF, 23'h0};
            4: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom_range(0, 7))};
            5: return {1'($urandom_range(0, 1)), 8'd127, 23'($urandom_range(0, 3))};
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_set(input int n);
        for (int k = 0; k < n; k++) send_key(pick_key(), k == n - 1);
    endtask

    task automatic test_directed();
        send_key(32'h3F80_0000, 1'b1);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7FC0_0000, 1'b0);
        send_key(32'hFF80_0000, 1'b0);
        send_key(32'h7F80_0000, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'h8000_0001, 1'b0);
        send_key(32'h7F7F_FFFF, 1'b0);
        send_key(32'hBF80_0000, 1'b0);
        send_key(32'h3F80_0000, 1'b0);
        send_key(32'h3F80_0000, 1'b1);
        send_key(32'h4000_0000, 1'b0);
        send_key(32'h3F80_0000, 1'b1);
    endtask

    task automatic test_overflow();
        for (int k = 0; k < MAX_KEYS + 3; k++) send_key(pick_key(), k == MAX_KEYS + 2);
        for (int k = 0; k < MAX_KEYS; k++) send_key($urandom(), k == MAX_KEYS - 1);
    endtask

    task automatic test_random();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        repeat (8) send_random_set($urandom_range(1, 9));
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        send_random_set(6);
        send_random_set(4);
        release_input();
        wait (sorted_queue.size() == 0);
        hold_req = 1'b0;
    endtask

    task automatic test_no_gaps();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (3) send_random_set($urandom_range(2, 8));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_idle    <= 0;
            hold_count   <= 0;
        end else if (hold_req && hold_count < HOLD_CYCLES) begin
            res_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else if (recv_idle != 0) begin
            res_ch.ready <= 1'b0;
            recv_idle    <= recv_idle - 1;
        end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            recv_idle    <= $urandom_range(0, 10);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sorted got;
        t_sorted want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.sorted_key, res_ch.origin_position, res_ch.last_result,
                   res_ch.keys_dropped};
            if (sorted_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
                want = sorted_queue.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch key %h/%h tag %0d/%0d last %b/%b drop %b/%b",
                                 want.key, got.key, want.tag, got.tag, want.last,
                                 got.last, want.dropped, got.dropped);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        key_ch.valid    = 1'b0;
        key_ch.key_bits = '0;
        key_ch.last_key = 1'b0;
        set_overflow    = 1'b0;
        send_gaps       = 1'b0;
        recv_gaps       = 1'b0;
        hold_req        = 1'b0;
        i_rst_n         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_overflow();
        test_no_gaps();
        release_input();
        wait (sorted_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && sorted_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
